>>> design/risc_instruction_execute_core_macros.svh
// Assertion shorthands shared by the execute core
`ifndef RISC_INSTRUCTION_EXECUTE_CORE_MACROS_SVH
`define RISC_INSTRUCTION_EXECUTE_CORE_MACROS_SVH
// Same-cycle implication, checked out of reset
`define RIEX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked out of reset
`define RIEX_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> design/riex_pkg.sv
package riex_pkg;

  localparam logic [31:0] RESET_PC    = 32'h0040_0000;
  localparam logic [31:0] DIV_ZERO_HI = 32'h7F80_0000;
  localparam logic [31:0] EXIT_CODE   = 32'd10;
  localparam logic [4:0]  REG_V0      = 5'd2;
  localparam logic [4:0]  REG_RA      = 5'd31;

  // Major opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_SLTIU   = 6'h0B;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SW      = 6'h2B;

  // SPECIAL function codes
  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_SLLV    = 6'h04;
  localparam logic [5:0] FN_SRLV    = 6'h06;
  localparam logic [5:0] FN_SRAV    = 6'h07;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_JALR    = 6'h09;
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_MFHI    = 6'h10;
  localparam logic [5:0] FN_MTHI    = 6'h11;
  localparam logic [5:0] FN_MFLO    = 6'h12;
  localparam logic [5:0] FN_MTLO    = 6'h13;
  localparam logic [5:0] FN_MULT    = 6'h18;
  localparam logic [5:0] FN_MULTU   = 6'h19;
  localparam logic [5:0] FN_DIV     = 6'h1A;
  localparam logic [5:0] FN_DIVU    = 6'h1B;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_SLT     = 6'h2A;
  localparam logic [5:0] FN_SLTU    = 6'h2B;

  // REGIMM rt codes
  localparam logic [4:0] RI_BLTZ   = 5'h00;
  localparam logic [4:0] RI_BGEZ   = 5'h01;
  localparam logic [4:0] RI_BLTZAL = 5'h10;
  localparam logic [4:0] RI_BGEZAL = 5'h11;

  // Memory request and store size codes
  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_READ  = 2'd1;
  localparam logic [1:0] MEM_WRITE = 2'd2;
  localparam logic [1:0] SZ_BYTE   = 2'd0;
  localparam logic [1:0] SZ_HALF   = 2'd1;
  localparam logic [1:0] SZ_WORD   = 2'd2;

  // Pending load kinds
  localparam logic [2:0] LK_W  = 3'd0;
  localparam logic [2:0] LK_B  = 3'd1;
  localparam logic [2:0] LK_BU = 3'd2;
  localparam logic [2:0] LK_H  = 3'd3;
  localparam logic [2:0] LK_HU = 3'd4;

  // Multiply/divide operations
  localparam logic [1:0] MD_MULT  = 2'd0;
  localparam logic [1:0] MD_MULTU = 2'd1;
  localparam logic [1:0] MD_DIV   = 2'd2;
  localparam logic [1:0] MD_DIVU  = 2'd3;

  typedef struct packed {
    logic        start;
    logic [1:0]  op;
    logic [31:0] a;
    logic [31:0] b;
  } md_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] hi;
    logic [31:0] lo;
  } md_rsp_t;

  // Everything one transaction commits
  typedef struct packed {
    logic [31:0] npc;
    logic [1:0]  mop;
    logic [31:0] addr;
    logic [31:0] sdata;
    logic [1:0]  ssize;
    logic        wen;
    logic [4:0]  widx;
    logic [31:0] wval;
    logic        halt;
    logic        unk;
    logic        hi_we;
    logic [31:0] hi;
    logic        lo_we;
    logic [31:0] lo;
    logic        ld_set;
    logic [2:0]  ld_kind;
    logic [4:0]  ld_dest;
    logic        ld_clr;
  } ex_t;

endpackage

>>> design/riex_regfile.sv
module riex_regfile (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [4:0]  rd_addr_a,
  input  logic [4:0]  rd_addr_b,
  output logic [31:0] rd_data_a,
  output logic [31:0] rd_data_b,
  input  logic        wr_en,
  input  logic [4:0]  wr_addr,
  input  logic [31:0] wr_data
);

  logic [31:0] mem [32];
  logic [31:0] valid_r;
  logic [31:0] data_a_r;
  logic [31:0] data_b_r;
  logic        vld_a_r;
  logic        vld_b_r;

  // Write port and two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    data_a_r <= mem[rd_addr_a];
    data_b_r <= mem[rd_addr_b];
  end

  // Track written entries; unwritten ones read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      vld_a_r <= valid_r[rd_addr_a];
      vld_b_r <= valid_r[rd_addr_b];
    end
  end

  assign rd_data_a = vld_a_r ? data_a_r : '0;
  assign rd_data_b = vld_b_r ? data_b_r : '0;

endmodule

>>> design/riex_muldiv.sv
module riex_muldiv (
  input  logic              clk,
  input  logic              rst_n,
  input  riex_pkg::md_req_t req,
  output riex_pkg::md_rsp_t rsp
);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_RUN  = 2'd1;
  localparam logic [1:0] M_FIX  = 2'd2;

  logic [1:0]  state_r;
  logic [4:0]  cnt_r;
  logic        is_div_r;
  logic        neg_q_r;
  logic        neg_r_r;
  logic [31:0] acc_hi_r;
  logic [31:0] acc_lo_r;
  logic [31:0] mcand_r;
  logic        done_r;
  logic [31:0] hi_r;
  logic [31:0] lo_r;

  logic        sgn;
  logic [31:0] ma;
  logic [31:0] mb;
  logic [32:0] msum;
  logic [32:0] trial;
  logic        ge;
  logic [32:0] tdiff;
  logic [63:0] prod_neg;

  assign sgn   = (req.op == riex_pkg::MD_MULT) || (req.op == riex_pkg::MD_DIV);
  assign ma    = (sgn && req.a[31]) ? (32'd0 - req.a) : req.a;
  assign mb    = (sgn && req.b[31]) ? (32'd0 - req.b) : req.b;
  assign msum  = {1'b0, acc_hi_r} + (acc_lo_r[0] ? {1'b0, mcand_r} : 33'd0);
  assign trial = {acc_hi_r, acc_lo_r[31]};
  assign ge    = trial >= {1'b0, mcand_r};
  assign tdiff = trial - {1'b0, mcand_r};
  assign prod_neg = 64'd0 - {acc_hi_r, acc_lo_r};

  // Sequence one bit per cycle, then fix signs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        M_IDLE: begin
          if (req.start) begin
            state_r <= M_RUN;
            cnt_r   <= '0;
          end
        end
        M_RUN: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) begin
            state_r <= M_FIX;
          end
        end
        M_FIX: begin
          state_r <= M_IDLE;
          done_r  <= 1'b1;
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

  // Datapath: shift-add multiply or restoring divide
  always_ff @(posedge clk) begin
    case (state_r)
      M_IDLE: begin
        if (req.start) begin
          is_div_r <= (req.op == riex_pkg::MD_DIV) || (req.op == riex_pkg::MD_DIVU);
          neg_q_r  <= sgn && (req.a[31] ^ req.b[31]);
          neg_r_r  <= sgn && req.a[31];
          acc_hi_r <= '0;
          acc_lo_r <= ma;
          mcand_r  <= mb;
        end
      end
      M_RUN: begin
        if (is_div_r) begin
          acc_hi_r <= ge ? tdiff[31:0] : trial[31:0];
          acc_lo_r <= {acc_lo_r[30:0], ge};
        end else begin
          {acc_hi_r, acc_lo_r} <= {msum, acc_lo_r[31:1]};
        end
      end
      M_FIX: begin
        if (is_div_r) begin
          lo_r <= neg_q_r ? (32'd0 - acc_lo_r) : acc_lo_r;
          hi_r <= neg_r_r ? (32'd0 - acc_hi_r) : acc_hi_r;
        end else begin
          {hi_r, lo_r} <= neg_q_r ? prod_neg : {acc_hi_r, acc_lo_r};
        end
      end
      default: ;
    endcase
  end

  assign rsp.done = done_r;
  assign rsp.hi   = hi_r;
  assign rsp.lo   = lo_r;

endmodule

>>> design/risc_instruction_execute_core.sv
// Integer execute core for the MIPS32 subset.
// Input channel (in_valid/in_ready): in_action 0 carries an instruction word
// fetched at out_next_pc of the previous result, 1 carries load data.
// Result channel (out_valid/out_ready): one result per transaction with the
// next fetch address, any memory request, the register written and flags.
// cfg_we/cfg_wdata loads the program counter; write only while idle.
// Most transactions pass through register-file read, execute and commit
// before out_valid rises; multiply and divide by a nonzero divisor also pass
// through the shared one-bit-per-cycle unit before commit.
// One transaction is in flight at a time; in_ready rises at the edge that
// commits a result, so a new transaction is accepted only once the last one
// has committed. The registered register-file read and the multiply/divide
// loop set this timing.
// Reset: program counter 0x00400000, registers, HI and LO read as zero.
// A stalled result stays in the output register; a new transaction may be
// accepted meanwhile but commits only once that result has been taken.
`include "risc_instruction_execute_core_macros.svh"
module risc_instruction_execute_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [31:0] in_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_next_pc,
  output logic [1:0]  out_mem_op,
  output logic [31:0] out_mem_address,
  output logic [31:0] out_store_data,
  output logic [1:0]  out_store_size,
  output logic        out_reg_written,
  output logic [4:0]  out_reg_index,
  output logic [31:0] out_reg_value,
  output logic        out_halted,
  output logic        out_unknown_instr,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_MD   = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic        act_r;
  logic [31:0] word_r;
  logic [31:0] pc_r;
  logic [31:0] hi_r;
  logic [31:0] lo_r;
  logic        ld_pend_r;
  logic [4:0]  ld_dest_r;
  logic [2:0]  ld_kind_r;
  logic        stopped_r;
  riex_pkg::ex_t ex_r, ex_c;
  logic        out_valid_r;
  riex_pkg::ex_t out_r;

  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rd, sh;
  logic [15:0] imm;
  logic [31:0] simm, a, b, pc4, bt, addr, ld_val;
  logic        md_go;
  logic [1:0]  md_op;
  logic        commit;
  logic        rf_we;
  logic [4:0]  rf_waddr;
  logic [4:0]  rf_ra;
  riex_pkg::md_req_t md_req;
  riex_pkg::md_rsp_t md_rsp;

  assign op   = word_r[31:26];
  assign rs   = word_r[25:21];
  assign rt   = word_r[20:16];
  assign rd   = word_r[15:11];
  assign sh   = word_r[10:6];
  assign fn   = word_r[5:0];
  assign imm  = word_r[15:0];
  assign simm = {{16{imm[15]}}, imm};
  assign pc4  = pc_r + 32'd4;
  assign bt   = pc_r + {simm[29:0], 2'b00};
  assign addr = a + simm;

  // Syscall reads v0 through port A
  assign rf_ra = (op == riex_pkg::OP_SPECIAL && fn == riex_pkg::FN_SYSCALL)
               ? riex_pkg::REG_V0 : rs;

  riex_regfile u_rf (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_addr_a (rf_ra),
    .rd_addr_b (rt),
    .rd_data_a (a),
    .rd_data_b (b),
    .wr_en     (rf_we),
    .wr_addr   (rf_waddr),
    .wr_data   (ex_r.wval)
  );

  assign md_req.start = (state_r == S_EXEC) && md_go;
  assign md_req.op    = md_op;
  assign md_req.a     = a;
  assign md_req.b     = b;

  riex_muldiv u_md (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .rsp   (md_rsp)
  );

  // Extend returned load data
  always_comb begin
    case (ld_kind_r)
      riex_pkg::LK_B:  ld_val = {{24{word_r[7]}}, word_r[7:0]};
      riex_pkg::LK_BU: ld_val = {24'd0, word_r[7:0]};
      riex_pkg::LK_H:  ld_val = {{16{word_r[15]}}, word_r[15:0]};
      riex_pkg::LK_HU: ld_val = {16'd0, word_r[15:0]};
      default:         ld_val = word_r;
    endcase
  end

  // Execute one transaction
  always_comb begin
    ex_c         = '0;
    ex_c.npc     = pc4;
    md_go        = 1'b0;
    md_op        = riex_pkg::MD_MULT;
    if (stopped_r) begin
      ex_c.npc  = pc_r;
      ex_c.halt = 1'b1;
    end else if (act_r) begin
      ex_c.npc = pc_r;
      if (ld_pend_r) begin
        ex_c.wen    = 1'b1;
        ex_c.widx   = ld_dest_r;
        ex_c.wval   = ld_val;
        ex_c.ld_clr = 1'b1;
      end
    end else if (ld_pend_r) begin
      ex_c.npc = pc_r;
    end else if (op == riex_pkg::OP_SPECIAL) begin
      ex_c.wen  = 1'b1;
      ex_c.widx = rd;
      case (fn)
        riex_pkg::FN_ADD, riex_pkg::FN_ADDU: ex_c.wval = a + b;
        riex_pkg::FN_SUB, riex_pkg::FN_SUBU: ex_c.wval = a - b;
        riex_pkg::FN_AND:  ex_c.wval = a & b;
        riex_pkg::FN_OR:   ex_c.wval = a | b;
        riex_pkg::FN_XOR:  ex_c.wval = a ^ b;
        riex_pkg::FN_NOR:  ex_c.wval = ~(a | b);
        riex_pkg::FN_SLT:  ex_c.wval = {31'd0, $signed(a) < $signed(b)};
        riex_pkg::FN_SLTU: ex_c.wval = {31'd0, a < b};
        riex_pkg::FN_SLL:  ex_c.wval = b << sh;
        riex_pkg::FN_SRL:  ex_c.wval = b >> sh;
        riex_pkg::FN_SRA:  ex_c.wval = $unsigned($signed(b) >>> sh);
        riex_pkg::FN_SLLV: ex_c.wval = b << a[4:0];
        riex_pkg::FN_SRLV: ex_c.wval = b >> a[4:0];
        riex_pkg::FN_SRAV: ex_c.wval = $unsigned($signed(b) >>> a[4:0]);
        riex_pkg::FN_JR: begin
          ex_c.wen = 1'b0;
          ex_c.npc = a;
        end
        riex_pkg::FN_JALR: begin
          ex_c.npc  = a;
          ex_c.wval = pc4;
        end
        riex_pkg::FN_MFHI: ex_c.wval = hi_r;
        riex_pkg::FN_MFLO: ex_c.wval = lo_r;
        riex_pkg::FN_MTHI: begin
          ex_c.wen   = 1'b0;
          ex_c.hi_we = 1'b1;
          ex_c.hi    = a;
        end
        riex_pkg::FN_MTLO: begin
          ex_c.wen   = 1'b0;
          ex_c.lo_we = 1'b1;
          ex_c.lo    = a;
        end
        riex_pkg::FN_MULT, riex_pkg::FN_MULTU: begin
          ex_c.wen = 1'b0;
          md_go    = 1'b1;
          md_op    = (fn == riex_pkg::FN_MULT) ? riex_pkg::MD_MULT : riex_pkg::MD_MULTU;
        end
        riex_pkg::FN_DIV, riex_pkg::FN_DIVU: begin
          ex_c.wen = 1'b0;
          md_op    = (fn == riex_pkg::FN_DIV) ? riex_pkg::MD_DIV : riex_pkg::MD_DIVU;
          if (b == 32'd0) begin
            ex_c.hi_we = 1'b1;
            ex_c.hi    = riex_pkg::DIV_ZERO_HI;
          end else begin
            md_go = 1'b1;
          end
        end
        riex_pkg::FN_SYSCALL: begin
          ex_c.wen  = 1'b0;
          ex_c.halt = (a == riex_pkg::EXIT_CODE);
        end
        default: begin
          ex_c.wen = 1'b0;
          ex_c.unk = 1'b1;
        end
      endcase
    end else if (op == riex_pkg::OP_J || op == riex_pkg::OP_JAL) begin
      ex_c.npc  = {pc_r[31:28], word_r[25:0], 2'b00};
      ex_c.wen  = (op == riex_pkg::OP_JAL);
      ex_c.widx = riex_pkg::REG_RA;
      ex_c.wval = pc4;
    end else begin
      ex_c.widx = rt;
      case (op)
        riex_pkg::OP_ADDI, riex_pkg::OP_ADDIU: begin
          ex_c.wen  = 1'b1;
          ex_c.wval = addr;
        end
        riex_pkg::OP_ANDI: begin
          ex_c.wen  = 1'b1;
          ex_c.wval = a & {16'd0, imm};
        end
        riex_pkg::OP_ORI: begin
          ex_c.wen  = 1'b1;
          ex_c.wval = a | {16'd0, imm};
        end
        riex_pkg::OP_XORI: begin
          ex_c.wen  = 1'b1;
          ex_c.wval = a ^ {16'd0, imm};
        end
        riex_pkg::OP_SLTI: begin
          ex_c.wen  = 1'b1;
          ex_c.wval = {31'd0, $signed(a) < $signed(simm)};
        end
        riex_pkg::OP_SLTIU: begin
          ex_c.wen  = 1'b1;
          ex_c.wval = {31'd0, a < simm};
        end
        riex_pkg::OP_LUI: begin
          ex_c.wen  = 1'b1;
          ex_c.wval = {imm, 16'd0};
        end
        riex_pkg::OP_BEQ:  if (a == b) ex_c.npc = bt;
        riex_pkg::OP_BNE:  if (a != b) ex_c.npc = bt;
        riex_pkg::OP_BLEZ: if ($signed(a) <= 0) ex_c.npc = bt;
        riex_pkg::OP_BGTZ: if ($signed(a) > 0) ex_c.npc = bt;
        riex_pkg::OP_REGIMM: begin
          ex_c.widx = riex_pkg::REG_RA;
          ex_c.wval = pc4;
          case (rt)
            riex_pkg::RI_BLTZ: if (a[31]) ex_c.npc = bt;
            riex_pkg::RI_BGEZ: if (!a[31]) ex_c.npc = bt;
            riex_pkg::RI_BLTZAL: begin
              ex_c.wen = 1'b1;
              if (a[31]) ex_c.npc = bt;
            end
            riex_pkg::RI_BGEZAL: begin
              ex_c.wen = 1'b1;
              if (!a[31]) ex_c.npc = bt;
            end
            default: ex_c.unk = 1'b1;
          endcase
        end
        riex_pkg::OP_LW, riex_pkg::OP_LB, riex_pkg::OP_LBU,
        riex_pkg::OP_LH, riex_pkg::OP_LHU: begin
          ex_c.ld_set  = 1'b1;
          ex_c.ld_dest = rt;
          ex_c.mop     = riex_pkg::MEM_READ;
          ex_c.addr    = addr;
          case (op)
            riex_pkg::OP_LB:  ex_c.ld_kind = riex_pkg::LK_B;
            riex_pkg::OP_LBU: ex_c.ld_kind = riex_pkg::LK_BU;
            riex_pkg::OP_LH:  ex_c.ld_kind = riex_pkg::LK_H;
            riex_pkg::OP_LHU: ex_c.ld_kind = riex_pkg::LK_HU;
            default:          ex_c.ld_kind = riex_pkg::LK_W;
          endcase
        end
        riex_pkg::OP_SB: begin
          ex_c.mop   = riex_pkg::MEM_WRITE;
          ex_c.addr  = addr;
          ex_c.ssize = riex_pkg::SZ_BYTE;
          ex_c.sdata = {24'd0, b[7:0]};
        end
        riex_pkg::OP_SH: begin
          ex_c.mop   = riex_pkg::MEM_WRITE;
          ex_c.addr  = addr;
          ex_c.ssize = riex_pkg::SZ_HALF;
          ex_c.sdata = {16'd0, b[15:0]};
        end
        riex_pkg::OP_SW: begin
          ex_c.mop   = riex_pkg::MEM_WRITE;
          ex_c.addr  = addr;
          ex_c.ssize = riex_pkg::SZ_WORD;
          ex_c.sdata = b;
        end
        default: ex_c.unk = 1'b1;
      endcase
    end
    // Drop writes to register zero and clear unused write fields
    if (ex_c.widx == 5'd0) begin
      ex_c.wen = 1'b0;
    end
    if (!ex_c.wen) begin
      ex_c.widx = '0;
      ex_c.wval = '0;
    end
  end

  assign commit   = (state_r == S_WB) && (!out_valid_r || out_ready);
  assign rf_we    = commit && ex_r.wen;
  assign rf_waddr = ex_r.widx;
  assign in_ready = (state_r == S_IDLE);

  // Sequence the transaction
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_READ;
      S_READ: state_nxt = S_EXEC;
      S_EXEC: state_nxt = md_go ? S_MD : S_WB;
      S_MD:   if (md_rsp.done) state_nxt = S_WB;
      S_WB:   if (commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= riex_pkg::RESET_PC;
      hi_r        <= '0;
      lo_r        <= '0;
      ld_pend_r   <= 1'b0;
      ld_dest_r   <= '0;
      ld_kind_r   <= riex_pkg::LK_W;
      stopped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // Present a committed result, drop it once taken
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      // Commit architectural state and load the result
      if (commit) begin
        pc_r        <= ex_r.npc;
        if (ex_r.hi_we) hi_r <= ex_r.hi;
        if (ex_r.lo_we) lo_r <= ex_r.lo;
        if (ex_r.ld_set) begin
          ld_pend_r <= 1'b1;
          ld_dest_r <= ex_r.ld_dest;
          ld_kind_r <= ex_r.ld_kind;
        end else if (ex_r.ld_clr) begin
          ld_pend_r <= 1'b0;
        end
        if (ex_r.halt) stopped_r <= 1'b1;
      end
      if (cfg_we) begin
        pc_r <= cfg_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      act_r  <= in_action;
      word_r <= in_word;
    end
    if (state_r == S_EXEC) begin
      ex_r <= ex_c;
    end else if (state_r == S_MD && md_rsp.done) begin
      ex_r.hi_we <= 1'b1;
      ex_r.hi    <= md_rsp.hi;
      ex_r.lo_we <= 1'b1;
      ex_r.lo    <= md_rsp.lo;
    end
    if (commit) begin
      out_r <= ex_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_next_pc       = out_r.npc;
  assign out_mem_op        = out_r.mop;
  assign out_mem_address   = out_r.addr;
  assign out_store_data    = out_r.sdata;
  assign out_store_size    = out_r.ssize;
  assign out_reg_written   = out_r.wen;
  assign out_reg_index     = out_r.widx;
  assign out_reg_value     = out_r.wval;
  assign out_halted        = out_r.halt;
  assign out_unknown_instr = out_r.unk;

  `RIEX_ASSERT_IMP(a_rf_no_zero, rf_we, rf_waddr != 5'd0, "register zero written")
  `RIEX_ASSERT_NXT(a_md_to_wb, (state_r == S_MD) && md_rsp.done, state_r == S_WB, "md done lost")
  `RIEX_ASSERT_NXT(a_commit_out, commit, out_valid_r, "committed result not presented")
  `RIEX_ASSERT_IMP(a_halt_stop, out_valid_r && out_halted, stopped_r, "halt without stop")

endmodule

>>> verif/riex_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the execute core, predicts every result from the
// accepted transactions and compares each returned result field by field.
module riex_checker
  import riex_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_action,
  input  logic [31:0] in_word,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_next_pc,
  input  logic [1:0]  out_mem_op,
  input  logic [31:0] out_mem_address,
  input  logic [31:0] out_store_data,
  input  logic [1:0]  out_store_size,
  input  logic        out_reg_written,
  input  logic [4:0]  out_reg_index,
  input  logic [31:0] out_reg_value,
  input  logic        out_halted,
  input  logic        out_unknown_instr,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output int          errors,
  output int          outstanding,
  output int          results_seen
);

  typedef struct packed {
    logic [31:0] next_pc;
    logic [1:0]  mem_op;
    logic [31:0] mem_address;
    logic [31:0] store_data;
    logic [1:0]  store_size;
    logic        reg_written;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        halted;
    logic        unknown_instr;
  } exec_result_t;

  // Architectural state of the core as the checker sees it
  logic [31:0]  gpr [32];
  logic [31:0]  pc_q, hi_q, lo_q;
  logic         ld_busy, stopped_q;
  logic [4:0]   ld_dest;
  logic [2:0]   ld_kind;
  exec_result_t expected_results [$];

  assign outstanding = expected_results.size();

  task automatic set_reg(inout exec_result_t r, input logic [4:0] idx,
                         input logic [31:0] v);
    if (idx != 5'd0) begin
      gpr[idx]      = v;
      r.reg_written = 1'b1;
      r.reg_index   = idx;
      r.reg_value   = v;
    end
  endtask

  task automatic execute_item(input logic act, input logic [31:0] w,
                              output exec_result_t r);
    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sh;
    logic [31:0] a, b, imm, simm, nxt, addr, target, v;
    logic [63:0] prod;
    longint      sa, sb;
    logic        unk;
    r         = '0;
    r.next_pc = pc_q;
    if (stopped_q) begin
      r.halted = 1'b1;
      return;
    end
    // Load data completes the pending load, else it is dropped
    if (act) begin
      if (!ld_busy) return;
      case (ld_kind)
        LK_B:    v = {{24{w[7]}}, w[7:0]};
        LK_BU:   v = {24'd0, w[7:0]};
        LK_H:    v = {{16{w[15]}}, w[15:0]};
        LK_HU:   v = {16'd0, w[15:0]};
        default: v = w;
      endcase
      set_reg(r, ld_dest, v);
      ld_busy = 1'b0;
      return;
    end
    if (ld_busy) return;

    op     = w[31:26];
    rs     = w[25:21];
    rt     = w[20:16];
    rd     = w[15:11];
    sh     = w[10:6];
    fn     = w[5:0];
    imm    = {16'd0, w[15:0]};
    simm   = {{16{w[15]}}, w[15:0]};
    a      = gpr[rs];
    b      = gpr[rt];
    nxt    = pc_q + 32'd4;
    target = pc_q + {simm[29:0], 2'b00};
    addr   = a + simm;
    unk    = 1'b0;

    if (op == OP_SPECIAL) begin
      case (fn)
        FN_ADD, FN_ADDU: set_reg(r, rd, a + b);
        FN_SUB, FN_SUBU: set_reg(r, rd, a - b);
        FN_AND:  set_reg(r, rd, a & b);
        FN_OR:   set_reg(r, rd, a | b);
        FN_XOR:  set_reg(r, rd, a ^ b);
        FN_NOR:  set_reg(r, rd, ~(a | b));
        FN_SLT:  set_reg(r, rd, {31'd0, $signed(a) < $signed(b)});
        FN_SLTU: set_reg(r, rd, {31'd0, a < b});
        FN_SLL:  set_reg(r, rd, b << sh);
        FN_SRL:  set_reg(r, rd, b >> sh);
        FN_SRA:  set_reg(r, rd, $signed(b) >>> sh);
        FN_SLLV: set_reg(r, rd, b << a[4:0]);
        FN_SRLV: set_reg(r, rd, b >> a[4:0]);
        FN_SRAV: set_reg(r, rd, $signed(b) >>> a[4:0]);
        FN_JR:   nxt = a;
        FN_JALR: begin
          nxt = a;
          set_reg(r, rd, pc_q + 32'd4);
        end
        FN_MFHI: set_reg(r, rd, hi_q);
        FN_MFLO: set_reg(r, rd, lo_q);
        FN_MTHI: hi_q = a;
        FN_MTLO: lo_q = a;
        FN_MULT: begin
          sa   = longint'($signed(a));
          sb   = longint'($signed(b));
          prod = sa * sb;
          {hi_q, lo_q} = prod;
        end
        FN_MULTU: begin
          prod = {32'd0, a} * {32'd0, b};
          {hi_q, lo_q} = prod;
        end
        FN_DIV: begin
          if (b == 32'd0) hi_q = DIV_ZERO_HI;
          else begin
            // 64-bit arithmetic keeps the most negative over minus one exact
            sa   = longint'($signed(a));
            sb   = longint'($signed(b));
            lo_q = 32'(sa / sb);
            hi_q = 32'(sa % sb);
          end
        end
        FN_DIVU: begin
          if (b == 32'd0) hi_q = DIV_ZERO_HI;
          else begin
            lo_q = a / b;
            hi_q = a % b;
          end
        end
        FN_SYSCALL: begin
          if (gpr[REG_V0] == EXIT_CODE) begin
            stopped_q = 1'b1;
            r.halted  = 1'b1;
          end
        end
        default: unk = 1'b1;
      endcase
    end else if (op == OP_J || op == OP_JAL) begin
      if (op == OP_JAL) set_reg(r, REG_RA, pc_q + 32'd4);
      nxt = {pc_q[31:28], w[25:0], 2'b00};
    end else begin
      case (op)
        OP_ADDI, OP_ADDIU: set_reg(r, rt, addr);
        OP_ANDI:  set_reg(r, rt, a & imm);
        OP_ORI:   set_reg(r, rt, a | imm);
        OP_XORI:  set_reg(r, rt, a ^ imm);
        OP_SLTI:  set_reg(r, rt, {31'd0, $signed(a) < $signed(simm)});
        OP_SLTIU: set_reg(r, rt, {31'd0, a < simm});
        OP_LUI:   set_reg(r, rt, {w[15:0], 16'd0});
        OP_BEQ:   if (a == b) nxt = target;
        OP_BNE:   if (a != b) nxt = target;
        OP_BLEZ:  if ($signed(a) <= 0) nxt = target;
        OP_BGTZ:  if ($signed(a) > 0) nxt = target;
        OP_REGIMM: begin
          case (rt)
            RI_BLTZ: if (a[31]) nxt = target;
            RI_BGEZ: if (!a[31]) nxt = target;
            RI_BLTZAL: begin
              set_reg(r, REG_RA, pc_q + 32'd4);
              if (a[31]) nxt = target;
            end
            RI_BGEZAL: begin
              set_reg(r, REG_RA, pc_q + 32'd4);
              if (!a[31]) nxt = target;
            end
            default: unk = 1'b1;
          endcase
        end
        OP_LW, OP_LB, OP_LBU, OP_LH, OP_LHU: begin
          case (op)
            OP_LW:   ld_kind = LK_W;
            OP_LB:   ld_kind = LK_B;
            OP_LBU:  ld_kind = LK_BU;
            OP_LH:   ld_kind = LK_H;
            default: ld_kind = LK_HU;
          endcase
          ld_dest       = rt;
          ld_busy       = 1'b1;
          r.mem_op      = MEM_READ;
          r.mem_address = addr;
        end
        OP_SB, OP_SH, OP_SW: begin
          r.mem_op      = MEM_WRITE;
          r.mem_address = addr;
          case (op)
            OP_SB: begin
              r.store_size = SZ_BYTE;
              r.store_data = {24'd0, b[7:0]};
            end
            OP_SH: begin
              r.store_size = SZ_HALF;
              r.store_data = {16'd0, b[15:0]};
            end
            default: begin
              r.store_size = SZ_WORD;
              r.store_data = b;
            end
          endcase
        end
        default: unk = 1'b1;
      endcase
    end
    pc_q            = nxt;
    r.next_pc       = nxt;
    r.unknown_instr = unk;
  endtask

  function automatic bit field_bad(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v === act_v) return 1'b0;
    if (errors < 10)
      $display("%0t mismatch in %s: expected %h, got %h", $realtime, name, exp_v, act_v);
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    exec_result_t predicted, seen;
    bit bad;
    if (!rst_n) begin
      foreach (gpr[i]) gpr[i] = '0;
      pc_q      = RESET_PC;
      hi_q      = '0;
      lo_q      = '0;
      ld_busy   = 1'b0;
      ld_dest   = '0;
      ld_kind   = LK_W;
      stopped_q = 1'b0;
      expected_results.delete();
      errors       <= 0;
      results_seen <= 0;
    end else begin
      // Writing the start address also reloads the program counter
      if (cfg_we) pc_q = cfg_wdata;
      if (in_valid && in_ready) begin
        execute_item(in_action, in_word, predicted);
        expected_results.push_back(predicted);
      end
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        seen = '{out_next_pc, out_mem_op, out_mem_address, out_store_data,
                 out_store_size, out_reg_written, out_reg_index, out_reg_value,
                 out_halted, out_unknown_instr};
        if (expected_results.size() == 0) begin
          if (errors < 10) $display("%0t result with nothing expected", $realtime);
          errors <= errors + 1;
        end else begin
          predicted = expected_results.pop_front();
          bad = 1'b0;
          bad |= field_bad("next_pc", predicted.next_pc, seen.next_pc);
          bad |= field_bad("mem_op", predicted.mem_op, seen.mem_op);
          bad |= field_bad("mem_address", predicted.mem_address, seen.mem_address);
          bad |= field_bad("store_data", predicted.store_data, seen.store_data);
          bad |= field_bad("store_size", predicted.store_size, seen.store_size);
          bad |= field_bad("reg_written", predicted.reg_written, seen.reg_written);
          bad |= field_bad("reg_index", predicted.reg_index, seen.reg_index);
          bad |= field_bad("reg_value", predicted.reg_value, seen.reg_value);
          bad |= field_bad("halted", predicted.halted, seen.halted);
          bad |= field_bad("unknown_instr", predicted.unknown_instr, seen.unknown_instr);
          if (bad) errors <= errors + 1;
        end
      end
    end
  end

endmodule

>>> verif/tb_risc_instruction_execute_core.sv
`timescale 1ns / 1ps

module tb_risc_instruction_execute_core;
  import riex_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam logic [5:0] FN_BREAK = 6'h0D;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_action = 1'b0;
  logic [31:0] in_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_next_pc, out_mem_address, out_store_data, out_reg_value;
  logic [1:0]  out_mem_op, out_store_size;
  logic        out_reg_written, out_halted, out_unknown_instr;
  logic [4:0]  out_reg_index;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  int errors, outstanding, results_seen;
  int idle_cycles = 0;
  int sent = 0;
  bit calm = 1'b0;
  bit load_waiting = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  risc_instruction_execute_core uut (.*);

  riex_checker chk (.*);

  // Receiver stalls about a quarter of the time unless in a calm stretch
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= calm || ($urandom_range(0, 99) >= 26);
  end

  // Abort when nothing moves on either channel for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [31:0] rtype(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                        logic [4:0] rd, logic [4:0] sh = 5'd0);
    return {OP_SPECIAL, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  // Present one transaction and hold it until accepted
  task automatic send(input logic act, input logic [31:0] w);
    logic [5:0] op;
    if (!calm && $urandom_range(0, 99) < 26) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_word   <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    // Track load pairing so the random part can follow a load with its data
    op = w[31:26];
    if (act) load_waiting = 1'b0;
    else if (!load_waiting && (op == OP_LW || op == OP_LB || op == OP_LBU ||
                               op == OP_LH || op == OP_LHU))
      load_waiting = 1'b1;
  endtask

  // Drain the core, let any multiply or divide finish, then write the start address
  task automatic load_start_pc(input logic [31:0] value);
    in_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (45) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                       : 5'($urandom_range(0, 7));
  endfunction

  function automatic logic [15:0] pick_imm();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'hFFFF;
      2: return 16'h7FFF;
      3: return 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  // Supported instruction with random operands, plus break and an unknown branch code; syscall is left out
  function automatic logic [31:0] random_instr();
    logic [5:0] fns [27] = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR,
                             FN_JALR, FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_MULT,
                             FN_MULTU, FN_DIV, FN_DIVU, FN_ADD, FN_ADDU, FN_SUB,
                             FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_NOR, FN_SLT, FN_SLTU,
                             FN_BREAK};
    logic [5:0] ops [23] = '{OP_REGIMM, OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ,
                             OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI,
                             OP_XORI, OP_LUI, OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU,
                             OP_SB, OP_SH, OP_SW};
    logic [4:0] ri [5] = '{RI_BLTZ, RI_BGEZ, RI_BLTZAL, RI_BGEZAL, 5'h1F};
    logic [5:0] op;
    if ($urandom_range(0, 2) == 0)
      return rtype(fns[$urandom_range(0, 26)], pick_reg(), pick_reg(), pick_reg(),
                   5'($urandom));
    op = ops[$urandom_range(0, 22)];
    if (op == OP_J || op == OP_JAL) return {op, 26'($urandom)};
    if (op == OP_REGIMM) return itype(op, pick_reg(), ri[$urandom_range(0, 4)], pick_imm());
    return itype(op, pick_reg(), pick_reg(), pick_imm());
  endfunction

  function automatic logic [31:0] load_data();
    logic [31:0] d = $urandom;
    if ($urandom_range(0, 1)) d[7] = 1'b1;
    if ($urandom_range(0, 1)) d[15] = 1'b1;
    return d;
  endfunction

  task automatic random_phase(input int count, input int calm_from, input int calm_to);
    int r;
    for (int i = 0; i < count; i++) begin
      calm = (i >= calm_from && i < calm_to);
      r = $urandom_range(0, 99);
      if (load_waiting) begin
        if (r < 90) send(1'b1, load_data());
        else send(1'b0, random_instr());
      end else if (r < 85) send(1'b0, random_instr());
      else if (r < 92) send(1'b1, $urandom);
      else begin
        // Raw word, but never a syscall so the run does not stop early
        logic [31:0] w = $urandom;
        if (w[31:26] == OP_SPECIAL && w[5:0] == FN_SYSCALL) w[0] = 1'b1;
        send(1'b0, w);
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: operand extremes, arithmetic corner cases and ignored transactions
    load_start_pc(32'h0000_0000);
    send(1'b0, itype(OP_LUI, 5'd0, 5'd1, 16'h8000));            // r1 = most negative
    send(1'b0, itype(OP_ADDIU, 5'd0, 5'd2, 16'hFFFF));          // r2 = -1
    send(1'b0, itype(OP_ORI, 5'd2, 5'd3, 16'hFFFF));
    send(1'b0, rtype(FN_SRL, 5'd0, 5'd2, 5'd4, 5'd1));          // r4 = most positive
    send(1'b0, rtype(FN_ADD, 5'd4, 5'd2, 5'd0));                // write to zero dropped
    send(1'b0, rtype(FN_ADD, 5'd4, 5'd4, 5'd5));                // wrap
    send(1'b0, rtype(FN_DIV, 5'd1, 5'd2, 5'd0));                // overflow divide
    send(1'b0, rtype(FN_MFLO, 5'd0, 5'd0, 5'd6));
    send(1'b0, rtype(FN_DIVU, 5'd1, 5'd0, 5'd0));               // divide by zero
    send(1'b0, rtype(FN_MFHI, 5'd0, 5'd0, 5'd7));
    send(1'b0, rtype(FN_MULT, 5'd1, 5'd2, 5'd0));
    send(1'b0, rtype(FN_MULTU, 5'd2, 5'd2, 5'd0));
    send(1'b0, rtype(FN_MFHI, 5'd0, 5'd0, 5'd6));
    send(1'b0, itype(OP_SLTIU, 5'd4, 5'd7, 16'hFFFF));
    send(1'b0, itype(OP_REGIMM, 5'd4, RI_BLTZAL, 16'h0004));    // link, not taken
    send(1'b0, itype(OP_REGIMM, 5'd4, 5'h05, 16'h0000));        // unknown branch code
    send(1'b0, rtype(FN_BREAK, 5'd0, 5'd0, 5'd0));
    send(1'b0, rtype(FN_SYSCALL, 5'd0, 5'd0, 5'd0));            // no exit code yet
    send(1'b1, 32'h1234_5678);                                  // data, no load
    send(1'b0, itype(OP_LB, 5'd1, 5'd8, 16'h8000));
    send(1'b0, itype(OP_ADDIU, 5'd0, 5'd9, 16'h0001));          // ignored while waiting
    send(1'b1, 32'h0000_0080);
    send(1'b0, itype(OP_SB, 5'd0, 5'd3, 16'h7FFF));
    send(1'b0, {OP_JAL, 26'h3FF_FFFF});
    send(1'b0, rtype(FN_JALR, 5'd3, 5'd0, 5'd31));

    // Random programs under several start addresses
    load_start_pc(32'hFFFF_FFFF);
    random_phase(290, 0, 0);
    load_start_pc(RESET_PC);
    random_phase(290, 60, 200);
    load_start_pc(32'hFFFF_FFFC);
    random_phase(290, 0, 0);
    load_start_pc($urandom);
    random_phase(290, 0, 0);
    load_start_pc(32'h7FFF_FFF0);
    random_phase(290, 0, 0);

    // Exit syscall, then transactions that must be ignored
    if (load_waiting) send(1'b1, load_data());
    send(1'b0, itype(OP_ADDIU, 5'd0, REG_V0, 16'd10));
    send(1'b0, rtype(FN_SYSCALL, 5'd0, 5'd0, 5'd0));
    send(1'b0, itype(OP_ADDIU, 5'd0, 5'd3, 16'd1));
    send(1'b1, 32'hFFFF_FFFF);

    in_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Sent %0d transactions over six start addresses, %0d results checked.",
             sent, results_seen);
    $display("Covered ALU, shifts, multiply/divide, branches, loads, stores and halt.");
    if (errors == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, outstanding);
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> risc_instruction_execute_core.f
+incdir+design
design/riex_pkg.sv
design/riex_regfile.sv
design/riex_muldiv.sv
design/risc_instruction_execute_core.sv
verif/riex_checker.sv
verif/tb_risc_instruction_execute_core.sv
